### hdl/slcan_ascii_can_bridge_unit_assert.svh
// Assertion macros shared by the bridge RTL.
`ifndef SLCAN_ASCII_CAN_BRIDGE_UNIT_ASSERT_SVH
`define SLCAN_ASCII_CAN_BRIDGE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SLCAN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcan assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SLCAN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcan assertion failed");

`endif

### hdl/slcan_pkg.sv
// Types, character codes and helper functions for the SLCAN bridge.
package slcan_pkg;

    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_BEL      = 8'd7;
    localparam logic [7:0] CH_ZERO     = "0";
    localparam logic [7:0] CH_UPPER_A  = "A";
    localparam logic [7:0] CH_ACK_EXT  = "Z";
    localparam logic [7:0] CH_ACK_STD  = "z";

    localparam logic [7:0] CMD_SETUP   = "S";
    localparam logic [7:0] CMD_VERSION = "V";
    localparam logic [7:0] CMD_SERIAL  = "N";
    localparam logic [7:0] CMD_FLAGS   = "F";
    localparam logic [7:0] CMD_OPEN    = "O";
    localparam logic [7:0] CMD_CLOSE   = "C";
    localparam logic [7:0] CMD_TX_EXT  = "T";
    localparam logic [7:0] CMD_TX_STD  = "t";
    localparam logic [7:0] CMD_RTR_EXT = "R";
    localparam logic [7:0] CMD_RTR_STD = "r";

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TX   = 2'd1,
        KIND_NOT  = 2'd2
    } t_kind;

    // What a request expands into on the output side.
    typedef enum logic [2:0] {
        JOB_NOT = 3'd0,
        JOB_BEL = 3'd1,
        JOB_CR  = 3'd2,
        JOB_VER = 3'd3,
        JOB_SER = 3'd4,
        JOB_FLG = 3'd5,
        JOB_TX  = 3'd6,
        JOB_RX  = 3'd7
    } t_job_type;

    typedef struct packed {
        t_job_type   jtype;
        logic [4:0]  last_idx;
        logic        ext;
        logic [31:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        ar;
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  chr;
        logic        last;
        logic        ext;
        logic [31:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        ar;
    } t_result;

    // Uppercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'd0, v};
        end
        return CH_UPPER_A + {4'd0, v} - 8'd10;
    endfunction

    // Hex digit decode, either case: {valid, value}.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, 4'(c - "0")};
        end
        if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end
        if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

endpackage

### hdl/slcan_ascii_can_bridge_unit.sv
// Top level of the SLCAN ASCII-to-CAN bridge.
//
//  channel   dir  tdata (low bit up)                              tuser      tlast
//  s_axis    in   host_char, mailbox_free, rx_extended, rx_id,    op         -
//                 rx_dlc, rx_data, zero pad to 112
//  m_axis    out  host_out_char, tx_extended, tx_id, tx_dlc,      kind       last
//                 tx_data, auto_retransmit, zero pad to 112
//
// A request is parsed in the cycle it is taken: the line state updates at once and any
// results are captured as one job. The job register then hands one result per cycle to
// the output register whenever the output register can load (it is empty or drained).
// Host characters other than CR give no result, a CR gives 1 to 6 results, and a
// received frame gives 6 to 27 while the bridge is open and none while it is closed.
// Reset (i_rst_n low at a clock edge) closes the bridge and empties the line, job and
// output register. A stall on m_axis holds the output word; s_axis stalls only while a
// job still has results to send past the current cycle.
module slcan_ascii_can_bridge_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] host_char, [8] mailbox_free, [9] rx_extended, [38:10] rx_id,
    // [42:39] rx_dlc, [106:43] rx_data, [111:107] zero
    input  logic [111:0] s_axis_tdata,
    // [0] op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] host_out_char, [8] tx_extended, [40:9] tx_id, [44:41] tx_dlc,
    // [108:45] tx_data, [109] auto_retransmit, [111:110] zero
    output logic [111:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import slcan_pkg::*;

    logic      in_take;
    logic      out_load;
    logic      job_adv;
    logic      job_done;
    logic      new_job_valid;
    t_job      new_job;
    t_result   fmt_res;

    logic      r_job_valid, n_job_valid;
    t_job      r_job, n_job;
    logic [4:0] r_idx, n_idx;
    logic      r_out_valid, n_out_valid;
    t_result   r_out, n_out;

    // Move a word into the output register whenever it is empty or being drained.
    assign out_load = !r_out_valid || m_axis_tready;
    assign job_adv  = r_job_valid && out_load;
    assign job_done = job_adv && (r_idx == r_job.last_idx);

    // Take a new request when the job slot is free or frees this cycle.
    assign s_axis_tready = !r_job_valid || job_done;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    slcan_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_take),
        .i_op           (s_axis_tuser),
        .i_host_char    (s_axis_tdata[7:0]),
        .i_mailbox_free (s_axis_tdata[8]),
        .i_rx_extended  (s_axis_tdata[9]),
        .i_rx_id        (s_axis_tdata[38:10]),
        .i_rx_dlc       (s_axis_tdata[42:39]),
        .i_rx_data      (s_axis_tdata[106:43]),
        .o_job_valid    (new_job_valid),
        .o_job          (new_job)
    );

    slcan_fmt u_fmt (
        .i_job (r_job),
        .i_idx (r_idx),
        .o_res (fmt_res)
    );

    always_comb begin
        n_job_valid = r_job_valid;
        n_job       = r_job;
        n_idx       = r_idx;
        if (job_done) begin
            n_job_valid = 1'b0;
        end else if (job_adv) begin
            n_idx = r_idx + 5'd1;
        end
        // Load the next job behind the one that finishes.
        if (in_take && new_job_valid) begin
            n_job_valid = 1'b1;
            n_job       = new_job;
            n_idx       = '0;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_load) begin
            n_out_valid = r_job_valid;
            n_out       = fmt_res;
            n_out.last  = (r_idx == r_job.last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {2'd0, r_out.ar, r_out.data, r_out.dlc, r_out.id,
                            r_out.ext, r_out.chr};

    `include "slcan_ascii_can_bridge_unit_assert.svh"

    // The emit index never runs past the job's final result.
    `SLCAN_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_job_valid, r_idx <= r_job.last_idx)
    // A request is only taken over a busy job when that job sends its last word now.
    `SLCAN_ASSERT_IMP(a_ready_on_done, i_clk, i_rst_n, s_axis_tready && r_job_valid, job_done)
    // A transmit request is always followed by its ack and CR.
    `SLCAN_ASSERT_IMP(a_tx_not_last, i_clk, i_rst_n, r_out_valid && (r_out.kind == KIND_TX),
        !r_out.last)
    // A finished job leaves the slot empty unless a new request refilled it.
    `SLCAN_ASSERT_NXT(a_job_clears, i_clk, i_rst_n, job_done && !in_take, !r_job_valid)

endmodule

### hdl/slcan_parse.sv
// Line parser: holds the SLCAN line state and turns each request into a job.
module slcan_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [7:0]         i_host_char,
    input  logic               i_mailbox_free,
    input  logic               i_rx_extended,
    input  logic [28:0]        i_rx_id,
    input  logic [3:0]         i_rx_dlc,
    input  logic [63:0]        i_rx_data,
    output logic               o_job_valid,
    output slcan_pkg::t_job    o_job
);
    import slcan_pkg::*;

    logic        r_open, n_open;
    logic [7:0]  r_cmd, n_cmd;
    logic [4:0]  r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic [3:0]  r_dlc, n_dlc;
    logic [63:0] r_data, n_data;
    logic [3:0]  r_high, n_high;
    logic        r_err, n_err;

    logic        is_t;
    logic        is_ext;
    logic [4:0]  id_len;
    logic [4:0]  nib;
    logic [7:0]  dval;
    logic [4:0]  k;
    logic [3:0]  bidx;
    logic [5:0]  need_len;
    logic [3:0]  rx_dlc_c;

    assign is_t     = (r_cmd == CMD_TX_EXT) || (r_cmd == CMD_TX_STD);
    assign is_ext   = (r_cmd == CMD_TX_EXT);
    assign id_len   = is_ext ? 5'd8 : 5'd3;
    assign nib      = nibble_of(i_host_char);
    assign dval     = i_host_char - CH_ZERO;
    assign k        = r_pos - id_len - 5'd2;
    assign bidx     = k[4:1];
    assign need_len = {1'b0, id_len + 5'd2} + {1'b0, r_dlc, 1'b0};
    assign rx_dlc_c = (i_rx_dlc > 4'd8) ? 4'd8 : i_rx_dlc;

    always_comb begin
        n_open      = r_open;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_id        = r_id;
        n_dlc       = r_dlc;
        n_data      = r_data;
        n_high      = r_high;
        n_err       = r_err;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job.jtype = JOB_NOT;
        o_job.ar    = r_open;

        if (i_accept) begin
            if (i_op) begin
                // Received frame: print only while open.
                o_job_valid   = r_open;
                o_job.jtype   = JOB_RX;
                o_job.ext     = i_rx_extended;
                o_job.id      = {3'd0, i_rx_id};
                o_job.dlc     = rx_dlc_c;
                o_job.data    = i_rx_data;
                o_job.last_idx = (i_rx_extended ? 5'd10 : 5'd5) + {rx_dlc_c, 1'b0};
            end else if (i_host_char == CH_CR) begin
                o_job_valid = 1'b1;
                if (r_pos == 5'd0) begin
                    o_job.jtype = JOB_NOT;
                end else begin
                    case (r_cmd)
                        CMD_SETUP: begin
                            o_job.jtype = JOB_CR;
                        end
                        CMD_VERSION: begin
                            o_job.jtype    = JOB_VER;
                            o_job.last_idx = 5'd5;
                        end
                        CMD_SERIAL: begin
                            o_job.jtype    = JOB_SER;
                            o_job.last_idx = 5'd5;
                        end
                        CMD_FLAGS: begin
                            o_job.jtype    = JOB_FLG;
                            o_job.last_idx = 5'd3;
                        end
                        CMD_OPEN: begin
                            n_open      = 1'b1;
                            o_job.jtype = JOB_CR;
                            o_job.ar    = 1'b1;
                        end
                        CMD_CLOSE: begin
                            n_open      = 1'b0;
                            o_job.jtype = JOB_CR;
                            o_job.ar    = 1'b0;
                        end
                        CMD_TX_EXT, CMD_TX_STD: begin
                            if (!r_open || r_err || ({1'b0, r_pos} < need_len) ||
                                !i_mailbox_free) begin
                                o_job.jtype = JOB_BEL;
                            end else begin
                                o_job.jtype    = JOB_TX;
                                o_job.last_idx = 5'd2;
                                o_job.ext      = is_ext;
                                o_job.id       = r_id;
                                o_job.dlc      = r_dlc;
                                o_job.data     = r_data;
                            end
                        end
                        CMD_RTR_EXT, CMD_RTR_STD: begin
                            o_job.jtype = JOB_BEL;
                        end
                        default: begin
                            o_job.jtype = JOB_NOT;
                        end
                    endcase
                end
                // Drop the line state after every CR.
                n_cmd  = '0;
                n_pos  = '0;
                n_id   = '0;
                n_dlc  = '0;
                n_data = '0;
                n_high = '0;
                n_err  = 1'b0;
            end else begin
                if (r_pos != 5'd31) begin
                    n_pos = r_pos + 5'd1;
                end
                if (r_pos == 5'd0) begin
                    n_cmd = i_host_char;
                end else if (is_t) begin
                    if (r_pos <= id_len) begin
                        if (nib[4]) begin
                            n_id = {r_id[27:0], nib[3:0]};
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_pos == id_len + 5'd1) begin
                        if (dval > 8'd8) begin
                            n_err = 1'b1;
                        end else begin
                            n_dlc = dval[3:0];
                        end
                    end else if (!r_err && (bidx < r_dlc)) begin
                        if (!nib[4]) begin
                            n_err = 1'b1;
                        end else if (!k[0]) begin
                            n_high = nib[3:0];
                        end else begin
                            n_data = r_data |
                                ({56'd0, r_high, nib[3:0]} << {3'd7 - bidx[2:0], 3'd0});
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_cmd  <= '0;
            r_pos  <= '0;
            r_id   <= '0;
            r_dlc  <= '0;
            r_data <= '0;
            r_high <= '0;
            r_err  <= 1'b0;
        end else begin
            r_open <= n_open;
            r_cmd  <= n_cmd;
            r_pos  <= n_pos;
            r_id   <= n_id;
            r_dlc  <= n_dlc;
            r_data <= n_data;
            r_high <= n_high;
            r_err  <= n_err;
        end
    end

endmodule

### hdl/slcan_fmt.sv
// Result formatter: gives result number idx of a job as one output word.
module slcan_fmt (
    input  slcan_pkg::t_job    i_job,
    input  logic [4:0]         i_idx,
    output slcan_pkg::t_result o_res
);
    import slcan_pkg::*;

    logic [4:0]  hdr;
    logic [4:0]  id_sel;
    logic [31:0] id_m;
    logic [4:0]  k;
    logic [3:0]  di;

    assign hdr    = i_job.ext ? 5'd9 : 5'd4;
    assign id_sel = (i_job.ext ? 5'd8 : 5'd3) - i_idx;
    assign id_m   = i_job.ext ? {3'd0, i_job.id[28:0]} : {21'd0, i_job.id[10:0]};
    assign k      = i_idx - hdr - 5'd1;
    assign di     = 4'd15 - k[3:0];

    always_comb begin
        o_res      = '0;
        o_res.kind = KIND_CHAR;
        o_res.ar   = i_job.ar;
        case (i_job.jtype)
            JOB_NOT: begin
                o_res.kind = KIND_NOT;
            end
            JOB_BEL: begin
                o_res.chr = CH_BEL;
            end
            JOB_CR: begin
                o_res.chr = CH_CR;
            end
            JOB_VER: begin
                case (i_idx)
                    5'd0:    o_res.chr = "V";
                    5'd1:    o_res.chr = "0";
                    5'd2:    o_res.chr = "1";
                    5'd3:    o_res.chr = "0";
                    5'd4:    o_res.chr = "1";
                    default: o_res.chr = CH_CR;
                endcase
            end
            JOB_SER: begin
                case (i_idx)
                    5'd0:    o_res.chr = "N";
                    5'd1:    o_res.chr = "A";
                    5'd2:    o_res.chr = "0";
                    5'd3:    o_res.chr = "0";
                    5'd4:    o_res.chr = "0";
                    default: o_res.chr = CH_CR;
                endcase
            end
            JOB_FLG: begin
                case (i_idx)
                    5'd0:    o_res.chr = "F";
                    5'd1:    o_res.chr = "0";
                    5'd2:    o_res.chr = "0";
                    default: o_res.chr = CH_CR;
                endcase
            end
            JOB_TX: begin
                if (i_idx == 5'd0) begin
                    o_res.kind = KIND_TX;
                    o_res.ext  = i_job.ext;
                    o_res.id   = i_job.id;
                    o_res.dlc  = i_job.dlc;
                    o_res.data = i_job.data;
                end else if (i_idx == 5'd1) begin
                    o_res.chr = i_job.ext ? CH_ACK_EXT : CH_ACK_STD;
                end else begin
                    o_res.chr = CH_CR;
                end
            end
            JOB_RX: begin
                if (i_idx == 5'd0) begin
                    o_res.chr = i_job.ext ? CMD_TX_EXT : CMD_TX_STD;
                end else if (i_idx < hdr) begin
                    o_res.chr = hex_char(id_m[{id_sel[2:0], 2'b00} +: 4]);
                end else if (i_idx == hdr) begin
                    o_res.chr = CH_ZERO + {4'd0, i_job.dlc};
                end else if (i_idx < i_job.last_idx) begin
                    o_res.chr = hex_char(i_job.data[{di, 2'b00} +: 4]);
                end else begin
                    o_res.chr = CH_CR;
                end
            end
            default: begin
                o_res.kind = KIND_NOT;
            end
        endcase
    end

endmodule

### tb/sv/slcan_ascii_can_bridge_unit_test.sv
// Self-checking stream testbench for the SLCAN ASCII-to-CAN bridge top level.
`timescale 1ns / 1ps

module slcan_ascii_can_bridge_unit_test;

    import slcan_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 90;
    // Worst case per request: 27 output words, each behind a stall, plus a sender
    // gap; a few hundred requests stay far below this.
    localparam int LIMIT_CYCLES = 1_000_000;
    // Longest job is 27 words; leave room for a stall on top.
    localparam int TAIL_CYCLES  = 60;
    localparam int LONG_HOLD    = 300;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_ONE
    } t_row_check;

    // One request on the input side.
    typedef struct {
        logic        op;
        logic [7:0]  chr;
        logic        mbox;
        logic        rx_ext;
        logic [28:0] rx_id;
        logic [3:0]  rx_dlc;
        logic [63:0] rx_data;
    } t_bridge_req;

    typedef struct {
        t_bridge_req req;
        t_row_check  chk;
        t_kind       kind;
        logic [7:0]  chr;
        logic        ar;
    } t_script_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    slcan_ascii_can_bridge_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bridge state as the predictor sees it
    // ------------------------------------------------------------------
    logic        link_open = 1'b0;
    logic [7:0]  cmd_char  = 8'd0;
    logic [4:0]  char_pos  = 5'd0;
    logic [31:0] id_acc    = 32'd0;
    logic [3:0]  dlc_val   = 4'd0;
    logic [63:0] data_acc  = 64'd0;
    logic [3:0]  hi_nib    = 4'd0;
    logic        bad_line  = 1'b0;

    string upper_hex = "0123456789ABCDEF";
    string lower_hex = "0123456789abcdef";

    t_result     step_out[$];     // words caused by the request being predicted
    t_result     replies_due[$];  // words still owed by the bridge, oldest first
    t_bridge_req line_q[$];       // requests of the line being composed

    logic [7:0] cmd_set[8] = '{CMD_SETUP, CMD_VERSION, CMD_SERIAL, CMD_FLAGS,
                               CMD_OPEN, CMD_CLOSE, CMD_RTR_EXT, CMD_RTR_STD};

    int errors           = 0;
    int cycle_count      = 0;
    int requests_sent    = 0;
    int rx_frames_sent   = 0;
    int results_checked  = 0;
    int tx_frames_seen   = 0;
    bit tx_calm          = 1'b0;
    bit rx_calm          = 1'b0;
    bit long_hold_done   = 1'b0;
    int hold_left        = 0;
    int stall_left       = 0;
    int rx_roll;
    logic rx_rdy;

    // Value of a hex digit in either case, -1 for anything else.
    function automatic int digit_value(logic [7:0] c);
        for (int i = 0; i < 16; i++) begin
            if (c == upper_hex[i] || c == lower_hex[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_upper(logic [3:0] v);
        return upper_hex[v];
    endfunction

    // Append one output word; every word carries the current open flag.
    function automatic void emit(t_kind k, logic [7:0] c);
        t_result r;
        r      = '0;
        r.kind = k;
        r.chr  = c;
        r.ar   = link_open;
        step_out.push_back(r);
    endfunction

    function automatic void emit_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(KIND_CHAR, s[i]);
        end
    endfunction

    // Fold one non-CR character into the line being parsed.
    function automatic void take_host_char(logic [7:0] c);
        int         p;
        int         id_len;
        int         dlc_at;
        int         k;
        int         idx;
        int         v;
        logic [7:0] d;
        p = char_pos;
        if (char_pos < 5'd31) begin
            char_pos = char_pos + 5'd1;
        end
        if (p == 0) begin
            cmd_char = c;
            return;
        end
        if (cmd_char != CMD_TX_EXT && cmd_char != CMD_TX_STD) begin
            return;
        end
        id_len = (cmd_char == CMD_TX_EXT) ? 8 : 3;
        dlc_at = id_len + 1;
        if (p <= id_len) begin
            v = digit_value(c);
            if (v < 0) begin
                bad_line = 1'b1;
            end else begin
                id_acc = {id_acc[27:0], 4'(v)};
            end
        end else if (p == dlc_at) begin
            d = c - CH_ZERO;
            if (d > 8'd8) begin
                bad_line = 1'b1;
            end else begin
                dlc_val = d[3:0];
            end
        end else if (!bad_line) begin
            k   = p - dlc_at - 1;
            idx = k >> 1;
            if (idx >= int'(dlc_val) || idx >= 8) begin
                return;
            end
            v = digit_value(c);
            if (v < 0) begin
                bad_line = 1'b1;
                return;
            end
            if (k % 2 == 0) begin
                hi_nib = 4'(v);
            end else begin
                data_acc = data_acc | ({56'd0, hi_nib, 4'(v)} << (56 - 8 * idx));
            end
        end
    endfunction

    // Act on a CR, then empty the line.
    function automatic void finish_line(logic mbox);
        logic    ext;
        int      dlc_at;
        t_result r;
        if (char_pos == 5'd0) begin
            emit(KIND_NOT, 8'd0);
        end else begin
            case (cmd_char)
                CMD_SETUP: emit(KIND_CHAR, CH_CR);
                CMD_VERSION: begin
                    emit_text("V0101");
                    emit(KIND_CHAR, CH_CR);
                end
                CMD_SERIAL: begin
                    emit_text("NA000");
                    emit(KIND_CHAR, CH_CR);
                end
                CMD_FLAGS: begin
                    emit_text("F00");
                    emit(KIND_CHAR, CH_CR);
                end
                CMD_OPEN: begin
                    link_open = 1'b1;
                    emit(KIND_CHAR, CH_CR);
                end
                CMD_CLOSE: begin
                    link_open = 1'b0;
                    emit(KIND_CHAR, CH_CR);
                end
                CMD_TX_EXT, CMD_TX_STD: begin
                    ext    = (cmd_char == CMD_TX_EXT);
                    dlc_at = ext ? 9 : 4;
                    // ring on closed bridge, short line, parse error or busy mailbox
                    if (!link_open || int'(char_pos) < dlc_at + 1 || bad_line ||
                        int'(char_pos) < dlc_at + 1 + 2 * int'(dlc_val) || !mbox) begin
                        emit(KIND_CHAR, CH_BEL);
                    end else begin
                        r      = '0;
                        r.kind = KIND_TX;
                        r.ext  = ext;
                        r.id   = id_acc;
                        r.dlc  = dlc_val;
                        r.data = data_acc;
                        r.ar   = link_open;
                        step_out.push_back(r);
                        emit(KIND_CHAR, ext ? CH_ACK_EXT : CH_ACK_STD);
                        emit(KIND_CHAR, CH_CR);
                    end
                end
                CMD_RTR_EXT, CMD_RTR_STD: emit(KIND_CHAR, CH_BEL);
                default: emit(KIND_NOT, 8'd0);
            endcase
        end
        cmd_char = 8'd0;
        char_pos = 5'd0;
        id_acc   = 32'd0;
        dlc_val  = 4'd0;
        data_acc = 64'd0;
        hi_nib   = 4'd0;
        bad_line = 1'b0;
    endfunction

    // Print a received CAN frame as hex text; silent while closed.
    function automatic void format_rx_frame(t_bridge_req q);
        logic [3:0]  dlc;
        logic [31:0] id;
        logic [7:0]  b;
        if (!link_open) begin
            return;
        end
        dlc = (q.rx_dlc > 4'd8) ? 4'd8 : q.rx_dlc;
        if (q.rx_ext) begin
            id = {3'd0, q.rx_id};
            emit(KIND_CHAR, CMD_TX_EXT);
            for (int i = 0; i < 8; i++) begin
                emit(KIND_CHAR, hex_upper(4'(id >> (28 - 4 * i))));
            end
        end else begin
            id = {21'd0, q.rx_id[10:0]};
            emit(KIND_CHAR, CMD_TX_STD);
            for (int i = 0; i < 3; i++) begin
                emit(KIND_CHAR, hex_upper(4'(id >> (8 - 4 * i))));
            end
        end
        emit(KIND_CHAR, CH_ZERO + 8'(dlc));
        for (int i = 0; i < int'(dlc); i++) begin
            b = 8'(q.rx_data >> (56 - 8 * i));
            emit(KIND_CHAR, hex_upper(b[7:4]));
            emit(KIND_CHAR, hex_upper(b[3:0]));
        end
        emit(KIND_CHAR, CH_CR);
    endfunction

    // Work out every word one accepted request causes; tag the final one.
    function automatic void predict(t_bridge_req q);
        step_out.delete();
        if (q.op) begin
            format_rx_frame(q);
        end else if (q.chr == CH_CR) begin
            finish_line(q.mbox);
        end else begin
            take_host_char(q.chr);
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [111:0] pack_req(t_bridge_req q);
        return {5'd0, q.rx_data, q.rx_dlc, q.rx_id, q.rx_ext, q.mbox, q.chr};
    endfunction

    // Host character with every unused field randomized.
    function automatic t_bridge_req noise_req();
        t_bridge_req q;
        q.op      = 1'b0;
        q.chr     = 8'($urandom);
        q.mbox    = 1'($urandom);
        q.rx_ext  = 1'($urandom);
        q.rx_id   = 29'($urandom);
        q.rx_dlc  = 4'($urandom);
        q.rx_data = {$urandom, $urandom};
        return q;
    endfunction

    function automatic void add_char(logic [7:0] c);
        t_bridge_req q;
        q     = noise_req();
        q.chr = c;
        line_q.push_back(q);
    endfunction

    function automatic logic [7:0] rand_hex_char(logic [3:0] v);
        if ($urandom_range(0, 1) == 0) begin
            return upper_hex[v];
        end
        return lower_hex[v];
    endfunction

    function automatic logic [7:0] rand_non_cr();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] c;
        do c = rand_non_cr(); while (digit_value(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] rand_bad_dlc();
        logic [7:0] c;
        do c = rand_non_cr(); while (c >= CH_ZERO && c <= CH_ZERO + 8'd8);
        return c;
    endfunction

    function automatic void add_tail(int max_len);
        int n;
        n = $urandom_range(1, max_len);
        repeat (n) add_char(rand_non_cr());
    endfunction

    // t or T line with random content; a broken one gets a single flaw.
    function automatic void build_frame(bit broken);
        logic ext;
        int   id_n;
        int   dlc;
        int   flaw;
        int   cut;
        ext  = 1'($urandom);
        id_n = ext ? 8 : 3;
        dlc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        add_char(ext ? CMD_TX_EXT : CMD_TX_STD);
        repeat (id_n) add_char(rand_hex_char(4'($urandom)));
        add_char(CH_ZERO + 8'(dlc));
        repeat (2 * dlc) add_char(rand_hex_char(4'($urandom)));
        if (broken) begin
            flaw = $urandom_range(0, 3);
            if (flaw == 2 && dlc == 0) begin
                flaw = 3;
            end
            case (flaw)
                0: line_q[$urandom_range(1, id_n)].chr = rand_junk();
                1: line_q[id_n + 1].chr = rand_bad_dlc();
                2: line_q[id_n + 2 + $urandom_range(0, 2 * dlc - 1)].chr = rand_junk();
                default: begin
                    // drop the end of the line: short id, no DLC or missing data
                    cut = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > cut) line_q.delete(line_q.size() - 1);
                end
            endcase
        end
        // long tails push the position counter into saturation
        if ($urandom_range(0, 4) == 0) begin
            add_tail(24);
        end
    endfunction

    // One random line, or a single received frame.
    function automatic void compose_line();
        int          pick;
        t_bridge_req q;
        line_q.delete();
        pick = $urandom_range(0, 99);
        if (!link_open && pick < 60) begin
            add_char(CMD_OPEN);
        end else if (pick < 55) begin
            build_frame(pick >= 40);
        end else if (pick < 70) begin
            q    = noise_req();
            q.op = 1'b1;
            line_q.push_back(q);
            return;
        end else if (pick < 85) begin
            add_char(cmd_set[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0) begin
                add_tail(4);
            end
        end else if (pick < 93) begin
            // unknown command, or a lone CR
            if ($urandom_range(0, 2) != 0) begin
                add_char(rand_non_cr());
                if ($urandom_range(0, 1) == 0) begin
                    add_tail(3);
                end
            end
        end else begin
            add_tail(6);
        end
        q      = noise_req();
        q.chr  = CH_CR;
        q.mbox = ($urandom_range(0, 4) != 0);
        line_q.push_back(q);
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    function automatic t_script_row host_row(logic [7:0] c, t_row_check chk, t_kind k,
                                             logic [7:0] ch, logic ar);
        t_script_row row;
        row.req      = noise_req();
        row.req.chr  = c;
        row.req.mbox = 1'b1;
        row.chk      = chk;
        row.kind     = k;
        row.chr      = ch;
        row.ar       = ar;
        return row;
    endfunction

    function automatic t_script_row rx_row(logic ext, logic [28:0] id, logic [3:0] dlc,
                                           logic [63:0] data, t_row_check chk);
        t_script_row row;
        row.req         = noise_req();
        row.req.op      = 1'b1;
        row.req.rx_ext  = ext;
        row.req.rx_id   = id;
        row.req.rx_dlc  = dlc;
        row.req.rx_data = data;
        row.chk         = chk;
        row.kind        = KIND_CHAR;
        row.chr         = 8'd0;
        row.ar          = 1'b0;
        return row;
    endfunction

    // Offer one request after a random gap, hold it until taken, then log
    // the words it owes: from the predictor, or a typed word for plain rows.
    task automatic send_req(input t_bridge_req q, input t_row_check chk, input t_result typed);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_req(q);
        s_axis_tuser  <= q.op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict(q);
        case (chk)
            CHK_PREDICT: foreach (step_out[i]) replies_due.push_back(step_out[i]);
            CHK_ONE: replies_due.push_back(typed);
            default: ;
        endcase
        requests_sent++;
        if (q.op) begin
            rx_frames_sent++;
        end
    endtask

    // Drop valid and hold until every owed word has come out.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure, with one long hold-off so the job
    // register fills and the input stalls while the sender keeps offering.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (cycle_count % 200 == 0) begin
            rx_calm = ($urandom_range(0, 2) == 0);
        end
        if (!long_hold_done && results_checked >= 20) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rx_rdy = 1'b0;
        end else if (rx_calm) begin
            rx_rdy = 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 65) begin
                rx_rdy = 1'b1;
            end else begin
                rx_rdy     = 1'b0;
                stall_left = (rx_roll < 92) ? $urandom_range(0, 2) : $urandom_range(9, 29);
            end
        end
        m_axis_tready <= rx_rdy;
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare each taken word with the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (replies_due.size() == 0) begin
                $error("unexpected output word: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = replies_due.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                check_field("host_out_char", 64'(want.chr), 64'(m_axis_tdata[7:0]));
                check_field("last", 64'(want.last), 64'(m_axis_tlast));
                check_field("tx_extended", 64'(want.ext), 64'(m_axis_tdata[8]));
                check_field("tx_id", 64'(want.id), 64'(m_axis_tdata[40:9]));
                check_field("tx_dlc", 64'(want.dlc), 64'(m_axis_tdata[44:41]));
                check_field("tx_data", want.data, m_axis_tdata[108:45]);
                check_field("auto_retransmit", 64'(want.ar), 64'(m_axis_tdata[109]));
                if (want.kind == KIND_TX) begin
                    tx_frames_seen++;
                end
            end
            results_checked++;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_script_row script[$];
        t_result     typed;
        int          rand_items;
        bit          paused;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: fixed replies, closed-bridge bells, open/close,
        // received frames at the field extremes and a short transmit line.
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_NOT, 8'd0, 1'b0));   // empty line
        script.push_back(host_row(CMD_SETUP, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_CHAR, CH_CR, 1'b0));
        script.push_back(host_row(CMD_VERSION, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_PREDICT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CMD_SERIAL, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_PREDICT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CMD_FLAGS, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_PREDICT, KIND_CHAR, 8'd0, 1'b0));
        // transmit while closed rings, a received frame is dropped
        script.push_back(host_row(CMD_TX_STD, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_CHAR, CH_BEL, 1'b0));
        script.push_back(rx_row(1'b1, '1, 4'hF, '1, CHK_SILENT));
        script.push_back(host_row(CMD_OPEN, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_CHAR, CH_CR, 1'b1));
        script.push_back(host_row(CMD_RTR_STD, CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_CHAR, CH_BEL, 1'b1));
        script.push_back(host_row("x", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));  // unknown
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_NOT, 8'd0, 1'b1));
        // extended frame with all ones and DLC 15, then an all-zero standard one
        script.push_back(rx_row(1'b1, '1, 4'hF, '1, CHK_PREDICT));
        script.push_back(rx_row(1'b0, '0, 4'h0, '0, CHK_PREDICT));
        // t7fF1Ff: highest standard id, mixed case, one byte
        script.push_back(host_row(CMD_TX_STD, CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("7", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("f", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("F", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("1", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("F", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row("f", CHK_SILENT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row(CH_CR, CHK_PREDICT, KIND_CHAR, 8'd0, 1'b1));
        script.push_back(host_row(CMD_CLOSE, CHK_SILENT, KIND_CHAR, 8'd0, 1'b0));
        script.push_back(host_row(CH_CR, CHK_ONE, KIND_CHAR, CH_CR, 1'b0));

        foreach (script[i]) begin
            typed      = '0;
            typed.kind = script[i].kind;
            typed.chr  = script[i].chr;
            typed.last = 1'b1;
            typed.ar   = script[i].ar;
            send_req(script[i].req, script[i].chk, typed);
        end

        // Random lines: mostly well-formed frames and commands, some broken
        // frames, received frames and noise. Pause once midway for a full drain.
        rand_items = 0;
        paused     = 1'b0;
        while (rand_items < RANDOM_ITEMS) begin
            compose_line();
            tx_calm = ($urandom_range(0, 3) == 0);
            foreach (line_q[i]) begin
                send_req(line_q[i], CHK_PREDICT, '0);
            end
            rand_items += line_q.size();
            if (!paused && rand_items >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_replies();
            end
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d received CAN frames) over %0d cycles.",
                 requests_sent, rx_frames_sent, cycle_count);
        $display("Checked %0d output words, %0d of them transmit frame requests.",
                 results_checked, tx_frames_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/slcan_pkg.sv
hdl/slcan_parse.sv
hdl/slcan_fmt.sv
hdl/slcan_ascii_can_bridge_unit.sv
tb/sv/slcan_ascii_can_bridge_unit_test.sv
